// ----- design/phm_pkg.sv -----
// Shared constants, types and handshake structs of the page home-node mapper.
package phm_pkg;

    // Address window and fixed field widths.
    localparam int GLOBAL_BITS = 32;
    localparam int MAX_NODES   = 64;
    localparam int PAGE_BITS   = 12;
    localparam int PAGE_BYTES  = 4096;
    localparam int ADDR_W      = 48;
    localparam int NODE_W      = 6;
    localparam int NCNT_W      = 7;
    localparam int BP_W        = 17;
    localparam int NSB_W       = 33;
    localparam int LOFF_W      = 32;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_IDX_W   = 3;

    // Internal widths derived from the address window.
    localparam int REL_W     = GLOBAL_BITS;
    localparam int PROD_W    = REL_W + 1 + BP_W;
    localparam int OFF_W     = REL_W + 31;
    localparam int DIV_CNT_W = $clog2(REL_W + 1);

    // Largest legal block size and share size.
    localparam logic [BP_W-1:0]  BP_MAX  = 17'h10000;
    localparam logic [NSB_W-1:0] NSB_MAX = 33'h100000000;

    // Placement policies.
    localparam logic [2:0] POL_BINDALL   = 3'd0;
    localparam logic [2:0] POL_CYCLIC    = 3'd1;
    localparam logic [2:0] POL_CYC_BLK   = 3'd2;
    localparam logic [2:0] POL_SKEW      = 3'd3;
    localparam logic [2:0] POL_SKEW_BLK  = 3'd4;
    localparam logic [2:0] POL_PRIME     = 3'd5;
    localparam logic [2:0] POL_PRIME_BLK = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd4;

    typedef logic [REL_W-1:0]     rel_t;
    typedef logic [NSB_W-1:0]     dvs_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [OFF_W-1:0]     off_t;
    typedef logic [DIV_CNT_W-1:0] divcnt_t;

    // Request to the shared divider.
    typedef struct packed {
        logic start;
        rel_t dividend;
        dvs_t divisor;
    } div_req_t;

    // Result of the shared divider, held until the next request.
    typedef struct packed {
        logic done;
        rel_t quot;
        dvs_t rem;
    } div_rsp_t;

endpackage

// ----- design/phm_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
module phm_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  phm_pkg::div_req_t req,
    output phm_pkg::div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    phm_pkg::divcnt_t     cnt_reg, cnt_next;
    phm_pkg::rel_t        dvd_reg, dvd_next;
    phm_pkg::dvs_t        rem_reg, rem_next;
    phm_pkg::dvs_t        dvs_reg, dvs_next;
    logic [phm_pkg::NSB_W:0] trial;
    logic [phm_pkg::NSB_W:0] diff;
    logic                 fits;

    // One trial subtraction of the shifted partial remainder.
    assign trial = {rem_reg, dvd_reg[phm_pkg::REL_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Next-state logic: load on a request, otherwise shift one bit.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = phm_pkg::divcnt_t'(phm_pkg::REL_W);
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[phm_pkg::NSB_W-1:0] : trial[phm_pkg::NSB_W-1:0];
            dvd_next = {dvd_reg[phm_pkg::REL_W-2:0], fits};
            cnt_next = cnt_reg - phm_pkg::divcnt_t'(1);
            if (cnt_reg == phm_pkg::divcnt_t'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- design/page_home_node_and_offset_mapper.sv -----
// Page home-node and local-offset mapper: sequencer, configuration and output stage.
//
//   Channel  | Direction | Handshake            | Contents
//   s_       | in        | s_tvalid / s_tready  | tdata: address
//   m_       | out       | m_tvalid / m_tready  | tdata: home_node, share offset; tuser: range_error
//   cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every quotient and remainder comes from one shared bit-serial divider. An item needs
// two divisions for bind-all and cyclic policies, four for skew and up to seven for the
// prime policies. Items are handled one at a time; the next is accepted as soon as the
// previous result sits in the output register. Reset is synchronous and needs no
// clearing pass. Configuration writes are always taken.
module page_home_node_and_offset_mapper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [phm_pkg::S_TDATA_W-1:0]   s_tdata,   // [47:0] address
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [phm_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] home_node, [37:6] share offset
    output logic [0:0]                      m_tuser,   // [0] range_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [phm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [phm_pkg::ADDR_W-1:0]      cfg_data
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CHECK = 5'd1;
    localparam logic [4:0] ST_BLK   = 5'd2;
    localparam logic [4:0] ST_HOME0 = 5'd3;
    localparam logic [4:0] ST_DN    = 5'd4;
    localparam logic [4:0] ST_SK1   = 5'd5;
    localparam logic [4:0] ST_SK2   = 5'd6;
    localparam logic [4:0] ST_PM    = 5'd7;
    localparam logic [4:0] ST_PN    = 5'd8;
    localparam logic [4:0] ST_PH    = 5'd9;
    localparam logic [4:0] ST_KCHK  = 5'd10;
    localparam logic [4:0] ST_K     = 5'd11;
    localparam logic [4:0] ST_KD    = 5'd12;
    localparam logic [4:0] ST_STOP  = 5'd13;
    localparam logic [4:0] ST_SPIS  = 5'd14;
    localparam logic [4:0] ST_SP    = 5'd15;
    localparam logic [4:0] ST_SN    = 5'd16;
    localparam logic [4:0] ST_MUL   = 5'd17;
    localparam logic [4:0] ST_SUM   = 5'd18;
    localparam logic [4:0] ST_FIN   = 5'd19;

    logic [4:0]                      state_reg, state_next;
    logic [2:0]                      policy_reg;
    logic [phm_pkg::NCNT_W-1:0]      ncnt_reg;
    logic [phm_pkg::BP_W-1:0]        bp_reg;
    logic [phm_pkg::NSB_W-1:0]       nsb_reg;
    logic [phm_pkg::ADDR_W-1:0]      base_reg;

    logic [phm_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    phm_pkg::rel_t                   rel_reg, rel_next;
    logic                            first_reg, first_next;
    phm_pkg::rel_t                   blk_reg, blk_next;
    logic [phm_pkg::BP_W-1:0]        inb_reg, inb_next;
    phm_pkg::rel_t                   qn_reg, qn_next;
    phm_pkg::rel_t                   cnt_reg, cnt_next;
    phm_pkg::rel_t                   qb_reg, qb_next;
    logic [6:0]                      r_reg, r_next;
    phm_pkg::rel_t                   hb_reg, hb_next;
    logic [phm_pkg::NODE_W-1:0]      home_reg, home_next;
    phm_pkg::rel_t                   kt_reg;
    phm_pkg::rel_t                   kq_reg, kq_next;
    logic [5:0]                      kr_reg, kr_next;
    phm_pkg::rel_t                   stop_reg, stop_next;
    phm_pkg::prod_t                  prod_reg, prod_next;
    phm_pkg::off_t                   off_reg, off_next;
    logic                            err_reg, err_next;

    logic                            m_valid_reg, m_valid_next;
    logic [phm_pkg::NODE_W-1:0]      m_home_reg, m_home_next;
    logic [phm_pkg::LOFF_W-1:0]      m_off_reg, m_off_next;
    logic                            m_err_reg, m_err_next;

    phm_pkg::div_req_t               div_req;
    phm_pkg::div_rsp_t               div_rsp;

    logic [phm_pkg::ADDR_W-1:0]      rel48;
    logic                            cfg_ok;
    logic                            blk_pol;
    logic [phm_pkg::BP_W-1:0]        bp_eff;
    logic [phm_pkg::REL_W-13:0]      page_c;
    logic [phm_pkg::REL_W-13:0]      lp_c;
    logic [8:0]                      tri_n;
    logic [7:0]                      pm_c;
    logic [7:0]                      d_c;
    phm_pkg::rel_t                   n_w;
    phm_pkg::rel_t                   pm_w;
    logic [phm_pkg::REL_W:0]         mval;

    // Shared divider.
    phm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Quantities derived from the configuration and the current address.
    assign rel48   = addr_reg - base_reg;
    assign cfg_ok  = (policy_reg <= phm_pkg::POL_PRIME_BLK) && (ncnt_reg != '0) &&
                     (ncnt_reg <= phm_pkg::NCNT_W'(phm_pkg::MAX_NODES)) &&
                     (bp_reg != '0) && (bp_reg <= phm_pkg::BP_MAX) &&
                     (nsb_reg != '0) && (nsb_reg <= phm_pkg::NSB_MAX);
    assign blk_pol = (policy_reg == phm_pkg::POL_CYC_BLK) ||
                     (policy_reg == phm_pkg::POL_SKEW_BLK) ||
                     (policy_reg == phm_pkg::POL_PRIME_BLK);
    assign bp_eff  = blk_pol ? bp_reg : phm_pkg::BP_W'(1);
    assign page_c  = rel48[phm_pkg::REL_W-1:phm_pkg::PAGE_BITS];
    assign lp_c    = (page_c != '0) ? page_c - 1'b1 : '0;
    assign tri_n   = {2'b00, ncnt_reg} + {1'b0, ncnt_reg, 1'b0};
    assign pm_c    = tri_n[8:1];
    assign d_c     = pm_c - {1'b0, ncnt_reg};
    assign n_w     = phm_pkg::rel_t'(ncnt_reg);
    assign pm_w    = phm_pkg::rel_t'(pm_c);
    assign mval    = {1'b0, qn_reg} + {1'b0, cnt_reg};

    // Sequencer: each waiting state ends on the divider's done pulse.
    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        rel_next     = rel_reg;
        first_next   = first_reg;
        blk_next     = blk_reg;
        inb_next     = inb_reg;
        qn_next      = qn_reg;
        cnt_next     = cnt_reg;
        qb_next      = qb_reg;
        r_next       = r_reg;
        hb_next      = hb_reg;
        home_next    = home_reg;
        kq_next      = kq_reg;
        kr_next      = kr_reg;
        stop_next    = stop_reg;
        prod_next    = prod_reg;
        off_next     = off_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_home_next  = m_home_reg;
        m_off_next   = m_off_reg;
        m_err_next   = m_err_reg;
        div_req      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    addr_next  = s_tdata;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next  = '0;
                home_next = '0;
                if (!cfg_ok || (addr_reg < base_reg) ||
                    ((rel48 >> phm_pkg::GLOBAL_BITS) != '0)) begin
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    err_next         = 1'b0;
                    rel_next         = rel48[phm_pkg::REL_W-1:0];
                    first_next       = page_c != '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = phm_pkg::rel_t'(lp_c);
                    div_req.divisor  = phm_pkg::dvs_t'(bp_eff);
                    state_next       = ST_BLK;
                end
            end
            ST_BLK: begin
                if (div_rsp.done) begin
                    blk_next      = div_rsp.quot;
                    inb_next      = div_rsp.rem[phm_pkg::BP_W-1:0];
                    div_req.start = 1'b1;
                    case (policy_reg)
                        phm_pkg::POL_BINDALL: begin
                            div_req.dividend = rel_reg;
                            div_req.divisor  = nsb_reg;
                            state_next       = ST_HOME0;
                        end
                        phm_pkg::POL_PRIME, phm_pkg::POL_PRIME_BLK: begin
                            div_req.dividend = div_rsp.quot;
                            div_req.divisor  = phm_pkg::dvs_t'(pm_c);
                            state_next       = ST_PM;
                        end
                        default: begin
                            div_req.dividend = div_rsp.quot;
                            div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                            state_next       = ST_DN;
                        end
                    endcase
                end
            end
            ST_HOME0: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= n_w) begin
                        err_next = 1'b1;
                    end else begin
                        home_next = div_rsp.quot[phm_pkg::NODE_W-1:0];
                        off_next  = phm_pkg::off_t'(div_rsp.rem);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_DN: begin
                if (div_rsp.done) begin
                    qn_next = div_rsp.quot;
                    if ((policy_reg == phm_pkg::POL_SKEW) ||
                        (policy_reg == phm_pkg::POL_SKEW_BLK)) begin
                        hb_next          = first_reg ? blk_reg : n_w - 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = first_reg ? blk_reg : n_w - 1'b1;
                        div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                        state_next       = ST_SK1;
                    end else begin
                        home_next  = div_rsp.rem[phm_pkg::NODE_W-1:0];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SK1: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = hb_reg + div_rsp.quot + 1'b1;
                    div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                    state_next       = ST_SK2;
                end
            end
            ST_SK2: begin
                if (div_rsp.done) begin
                    home_next  = div_rsp.rem[phm_pkg::NODE_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_PM: begin
                if (div_rsp.done) begin
                    qb_next          = div_rsp.quot;
                    r_next           = div_rsp.rem[6:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = blk_reg;
                    div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                    state_next       = ST_PN;
                end
            end
            ST_PN: begin
                if (div_rsp.done) begin
                    qn_next = div_rsp.quot;
                    if (r_reg >= ncnt_reg) begin
                        // Blocks in the extra columns of the prime pattern.
                        div_req.start    = 1'b1;
                        div_req.dividend = kt_reg + phm_pkg::rel_t'(r_reg) - n_w;
                        div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                        state_next       = ST_PH;
                    end else begin
                        home_next = r_reg[phm_pkg::NODE_W-1:0];
                        if (first_reg && (blk_reg >= n_w)) begin
                            state_next = ST_KCHK;
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_PH: begin
                if (div_rsp.done) begin
                    home_next  = div_rsp.rem[phm_pkg::NODE_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_KCHK: begin
                // Find the nearest earlier block of this node with a known offset.
                if ((d_c != '0) && (kt_reg > phm_pkg::rel_t'(home_reg))) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = kt_reg - 1'b1 - phm_pkg::rel_t'(home_reg);
                    div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                    state_next       = ST_K;
                end else begin
                    stop_next  = phm_pkg::rel_t'(home_reg);
                    state_next = ST_SPIS;
                end
            end
            ST_K: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = kt_reg - 1'b1 - phm_pkg::rel_t'(div_rsp.rem);
                    div_req.divisor  = phm_pkg::dvs_t'(d_c);
                    state_next       = ST_KD;
                end
            end
            ST_KD: begin
                if (div_rsp.done) begin
                    kq_next    = div_rsp.quot;
                    kr_next    = div_rsp.rem[5:0];
                    state_next = ST_STOP;
                end
            end
            ST_STOP: begin
                stop_next  = phm_pkg::rel_t'(kq_reg * pm_w) + n_w + phm_pkg::rel_t'(kr_reg);
                state_next = ST_SPIS;
            end
            ST_SPIS: begin
                div_req.start    = 1'b1;
                div_req.dividend = stop_reg - phm_pkg::rel_t'(home_reg);
                div_req.divisor  = phm_pkg::dvs_t'(pm_c);
                state_next       = ST_SP;
            end
            ST_SP: begin
                if (div_rsp.done) begin
                    cnt_next         = qb_reg - div_rsp.quot;
                    div_req.start    = 1'b1;
                    div_req.dividend = stop_reg;
                    div_req.divisor  = phm_pkg::dvs_t'(ncnt_reg);
                    state_next       = ST_SN;
                end
            end
            ST_SN: begin
                if (div_rsp.done) begin
                    qn_next    = div_rsp.quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = phm_pkg::prod_t'(mval) * phm_pkg::prod_t'(bp_eff);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                off_next = phm_pkg::off_t'({prod_reg, {phm_pkg::PAGE_BITS{1'b0}}}) +
                           phm_pkg::off_t'({inb_reg, {phm_pkg::PAGE_BITS{1'b0}}}) +
                           ((first_reg && (home_reg == '0)) ?
                               phm_pkg::off_t'(phm_pkg::PAGE_BYTES) : '0) +
                           phm_pkg::off_t'(rel_reg[phm_pkg::PAGE_BITS-1:0]);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (err_reg || (off_reg >= phm_pkg::off_t'(nsb_reg))) begin
                        m_err_next  = 1'b1;
                        m_home_next = '0;
                        m_off_next  = '0;
                    end else begin
                        m_err_next  = 1'b0;
                        m_home_next = home_reg;
                        m_off_next  = off_reg[phm_pkg::LOFF_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            policy_reg  <= phm_pkg::POL_BINDALL;
            ncnt_reg    <= phm_pkg::NCNT_W'(1);
            bp_reg      <= phm_pkg::BP_W'(1);
            nsb_reg     <= phm_pkg::NSB_MAX;
            base_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    phm_pkg::CFG_POLICY: policy_reg <= cfg_data[2:0];
                    phm_pkg::CFG_NODES:  ncnt_reg   <= cfg_data[phm_pkg::NCNT_W-1:0];
                    phm_pkg::CFG_BLOCK:  bp_reg     <= cfg_data[phm_pkg::BP_W-1:0];
                    phm_pkg::CFG_SHARE:  nsb_reg    <= cfg_data[phm_pkg::NSB_W-1:0];
                    phm_pkg::CFG_BASE:   base_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        rel_reg    <= rel_next;
        first_reg  <= first_next;
        blk_reg    <= blk_next;
        inb_reg    <= inb_next;
        qn_reg     <= qn_next;
        cnt_reg    <= cnt_next;
        qb_reg     <= qb_next;
        r_reg      <= r_next;
        hb_reg     <= hb_next;
        home_reg   <= home_next;
        kt_reg     <= phm_pkg::rel_t'(qb_reg * d_c);
        kq_reg     <= kq_next;
        kr_reg     <= kr_next;
        stop_reg   <= stop_next;
        prod_reg   <= prod_next;
        off_reg    <= off_next;
        err_reg    <= err_next;
        m_home_reg <= m_home_next;
        m_off_reg  <= m_off_next;
        m_err_reg  <= m_err_next;
    end

    // Port drive.
    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_off_reg, m_home_reg};
    assign m_tuser   = m_err_reg;

    // An error result carries zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result with non-zero fields");

    // A good result names a node below the configured node count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[phm_pkg::NODE_W-1:0] < ncnt_reg))
        else $error("home node beyond node count");

    // An accepted transaction closes the input until its result is staged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> ((state_reg == ST_BLK) || (state_reg == ST_HOME0) ||
                          (state_reg == ST_DN) || (state_reg == ST_SK1) ||
                          (state_reg == ST_SK2) || (state_reg == ST_PM) ||
                          (state_reg == ST_PN) || (state_reg == ST_PH) ||
                          (state_reg == ST_K) || (state_reg == ST_KD) ||
                          (state_reg == ST_SP) || (state_reg == ST_SN)))
        else $error("divider result arrived outside a waiting state");

endmodule

// ----- sim/phm_checker.sv -----
// Checker of the page home-node mapper: follows the channels, predicts each result and compares.
module phm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [phm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [phm_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [phm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [phm_pkg::ADDR_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              open_count,
    output int                              result_count,
    output int                              error_count,
    output int                              cfg_count
);

    // One predicted mapping.
    typedef struct {
        logic [phm_pkg::NODE_W-1:0] home;
        logic [phm_pkg::LOFF_W-1:0] offset;
        logic                       range_err;
    } mapping_t;

    mapping_t pending_maps[$];

    // Private copy of the configuration registers.
    logic [2:0]                 policy_q;
    logic [phm_pkg::NCNT_W-1:0] nodes_q;
    logic [phm_pkg::BP_W-1:0]   block_q;
    logic [phm_pkg::NSB_W-1:0]  share_q;
    logic [phm_pkg::ADDR_W-1:0] base_q;

    // Works out the owner and the local offset of one address.
    function automatic mapping_t map_address(logic [phm_pkg::ADDR_W-1:0] addr);
        mapping_t m;
        logic [63:0] a, n, rel, bp, bsz, fine, aligned, less, blk, inblk;
        logic [63:0] home, off, hb, pm, r, qb, d, stop, cnt, kt, k;
        bit first, is_blk;
        m.home = '0;
        m.offset = '0;
        m.range_err = 1'b1;
        a = 64'(addr);
        n = 64'(nodes_q);
        if (!(policy_q <= phm_pkg::POL_PRIME_BLK && n >= 1 && n <= phm_pkg::MAX_NODES &&
              block_q >= 1 && block_q <= phm_pkg::BP_MAX && share_q >= 1 &&
              share_q <= phm_pkg::NSB_MAX && a >= 64'(base_q)))
            return m;
        rel = a - 64'(base_q);
        if (rel >= (64'd1 << phm_pkg::GLOBAL_BITS))
            return m;
        is_blk = policy_q == phm_pkg::POL_CYC_BLK || policy_q == phm_pkg::POL_SKEW_BLK ||
                 policy_q == phm_pkg::POL_PRIME_BLK;
        bp = is_blk ? 64'(block_q) : 64'd1;
        bsz = bp * phm_pkg::PAGE_BYTES;
        fine = rel % phm_pkg::PAGE_BYTES;
        aligned = rel - fine;
        first = aligned >= phm_pkg::PAGE_BYTES;
        less = first ? aligned - phm_pkg::PAGE_BYTES : 64'd0;
        blk = less / bsz;
        inblk = less % bsz;

        if (policy_q == phm_pkg::POL_BINDALL) begin
            home = rel / 64'(share_q);
            if (home >= n)
                return m;
            off = rel - home * 64'(share_q);
        end else if (policy_q <= phm_pkg::POL_SKEW_BLK) begin
            if (policy_q <= phm_pkg::POL_CYC_BLK) begin
                home = blk % n;
            end else begin
                hb = first ? blk : n - 1;
                home = (hb + hb / n + 1) % n;
            end
            off = (blk / n) * bsz + inblk +
                  ((first && home == 0) ? phm_pkg::PAGE_BYTES : 0) + fine;
        end else begin
            pm = (3 * n) / 2;
            r = blk % pm;
            home = (r >= n) ? ((blk / pm) * (pm - n) + (r - n)) % n : r;
            if (!first || blk < n || r >= n) begin
                off = (blk / n) * bsz + inblk +
                      ((first && home == 0) ? phm_pkg::PAGE_BYTES : 0) + fine;
            end else begin
                // Count back to the nearest earlier block of this node placed directly.
                qb = blk / pm;
                d = pm - n;
                stop = home;
                if (d > 0) begin
                    kt = qb * d;
                    if (kt > home) begin
                        k = (kt - 1) - ((kt - 1 - home) % n);
                        stop = (k / d) * pm + n + (k % d);
                    end
                end
                cnt = qb - (stop - home) / pm;
                off = (stop / n) * bsz + inblk + (home == 0 ? phm_pkg::PAGE_BYTES : 0) +
                      cnt * bsz + fine;
            end
        end
        if (off >= 64'(share_q))
            return m;
        m.home = home[phm_pkg::NODE_W-1:0];
        m.offset = off[phm_pkg::LOFF_W-1:0];
        m.range_err = 1'b0;
        return m;
    endfunction

    // Prints one mismatch and counts it.
    task automatic report(string what, longint got, longint want);
        $display("%0t: %s differs: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        open_count = 0;
        result_count = 0;
        error_count = 0;
        cfg_count = 0;
    end

    // Follows every transaction on the three channels.
    always @(posedge aclk) begin
        mapping_t want;
        if (!aresetn) begin
            policy_q <= phm_pkg::POL_BINDALL;
            nodes_q <= 7'd1;
            block_q <= 17'd1;
            share_q <= phm_pkg::NSB_MAX;
            base_q <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_count++;
                case (cfg_index)
                    phm_pkg::CFG_POLICY: policy_q <= cfg_data[2:0];
                    phm_pkg::CFG_NODES:  nodes_q <= cfg_data[phm_pkg::NCNT_W-1:0];
                    phm_pkg::CFG_BLOCK:  block_q <= cfg_data[phm_pkg::BP_W-1:0];
                    phm_pkg::CFG_SHARE:  share_q <= cfg_data[phm_pkg::NSB_W-1:0];
                    phm_pkg::CFG_BASE:   base_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_maps.push_back(map_address(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count++;
                if (m_tuser[0])
                    error_count++;
                if (pending_maps.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    want = pending_maps.pop_front();
                    if (m_tdata[phm_pkg::NODE_W-1:0] !== want.home)
                        report("home_node", m_tdata[phm_pkg::NODE_W-1:0], want.home);
                    if (m_tdata[phm_pkg::NODE_W+phm_pkg::LOFF_W-1:phm_pkg::NODE_W] !==
                        want.offset)
                        report("share offset",
                               m_tdata[phm_pkg::NODE_W+phm_pkg::LOFF_W-1:phm_pkg::NODE_W],
                               want.offset);
                    if (m_tuser[0] !== want.range_err)
                        report("range_error", m_tuser[0], want.range_err);
                end
            end
            open_count = pending_maps.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the mapper testbench: clock, reset, stimulus phases and the verdict.
module testbench;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [phm_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [phm_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0]                    m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [phm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [phm_pkg::ADDR_W-1:0]    cfg_data = '0;

    int fail_count, open_count, result_count, error_count, cfg_count;
    int items_sent = 0;
    bit quiet = 0;
    int hold_request = 0;
    longint cycles = 0;

    // Settings of the current phase, used to aim the addresses.
    logic [63:0] cur_nodes = 1, cur_block = 1, cur_base = 0;

    page_home_node_and_offset_mapper uut (.*);

    phm_checker checker_i (.*);

    // Clock with a period of four units.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cycle limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver: random stalls, a quiet mode, and long hold-offs on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 9);
            end
        end
    end

    // Writes one configuration register.
    task automatic cfg_write(logic [phm_pkg::CFG_IDX_W-1:0] idx,
                             logic [phm_pkg::ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one address; the valid stays high into the next transaction where possible.
    task automatic send_address(logic [phm_pkg::ADDR_W-1:0] addr);
        int gap;
        if (!quiet && $urandom_range(99) < 9) begin
            gap = $urandom_range(6, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Lowers the valid and waits until every result has come back.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (open_count != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Loads a full configuration while the mapper is idle.
    task automatic configure(logic [2:0] pol, logic [6:0] nodes, logic [16:0] blk,
                             logic [32:0] share, logic [47:0] base);
        cfg_write(phm_pkg::CFG_POLICY, 48'(pol));
        cfg_write(phm_pkg::CFG_NODES, 48'(nodes));
        cfg_write(phm_pkg::CFG_BLOCK, 48'(blk));
        cfg_write(phm_pkg::CFG_SHARE, 48'(share));
        cfg_write(phm_pkg::CFG_BASE, base);
        cur_nodes = (nodes == 0) ? 1 : nodes;
        cur_block = (blk == 0) ? 1 : blk;
        cur_base = base;
    endtask

    // Picks an address: mostly inside the first few rounds of blocks, plus edges and noise.
    function automatic logic [47:0] pick_address();
        logic [63:0] span, rel;
        int r;
        r = $urandom_range(99);
        span = cur_nodes * cur_block * phm_pkg::PAGE_BYTES * 12;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        if (r < 6)
            return {$urandom, $urandom};
        if (r < 10)
            return 48'(cur_base - 1 - $urandom_range(8192));
        if (r < 14)
            return 48'(cur_base + 64'h1_0000_0000 + $urandom_range(1, 0) * $urandom);
        if (r < 22) begin
            rel = 64'($urandom_range(40)) * phm_pkg::PAGE_BYTES;
            case ($urandom_range(2))
                0: rel = rel + 1;
                1: rel = rel + phm_pkg::PAGE_BYTES - 1;
                default: ;
            endcase
            return 48'(cur_base + rel);
        end
        if (r < 45)
            return 48'(cur_base + 64'($urandom));
        rel = {$urandom, $urandom} % (span + 1);
        return 48'(cur_base + rel);
    endfunction

    // Random configuration, legal most of the time.
    task automatic random_phase(int count);
        logic [6:0] nodes;
        logic [16:0] blk;
        logic [32:0] share;
        logic [47:0] base;
        logic [2:0] pol;
        pol = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(phm_pkg::POL_PRIME_BLK));
        nodes = ($urandom_range(19) == 0) ? 7'($urandom) :
                                            7'($urandom_range(phm_pkg::MAX_NODES, 1));
        case ($urandom_range(3))
            0: blk = 17'($urandom_range(4, 1));
            1: blk = 17'($urandom_range(phm_pkg::BP_MAX, 1));
            2: blk = 17'($urandom);
            default: blk = 17'($urandom_range(64, 1));
        endcase
        case ($urandom_range(3))
            0: share = phm_pkg::NSB_MAX;
            1: share = 33'($urandom_range(32'hFFFF_FFFF, 1));
            2: share = {$urandom, 1'b0} | 33'($urandom);
            default: share = 33'($urandom_range(32'h0400_0000, 4096));
        endcase
        base = ($urandom_range(2) == 0) ? 48'd0 : {$urandom, $urandom};
        configure(pol, nodes, blk, share, base);
        repeat (count)
            send_address(pick_address());
        drain();
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults after reset: window edges and a full-width address.
        send_address(48'h0);
        send_address(48'h0000_FFFF_FFFF);
        send_address(48'h0001_0000_0000);
        send_address(48'hFFFF_FFFF_FFFF);
        drain();

        // Writes to indexes beyond the register list are ignored.
        cfg_write(3'd5, 48'hFFFF_FFFF_FFFF);
        cfg_write(3'd6, 48'h5555_5555_5555);
        cfg_write(3'd7, 48'hAAAA_AAAA_AAAA);

        // Every policy once, with the first page, the page after it and a later page.
        for (int p = phm_pkg::POL_BINDALL; p <= phm_pkg::POL_PRIME_BLK; p++) begin
            configure(3'(p), 7'd5, 17'd3, 33'h0010_0000, 48'h0000_1234_5000);
            send_address(48'h0000_1234_5000);
            send_address(48'h0000_1234_6FFF);
            send_address(48'h0000_1234_5000 + 48'h9_3000);
            drain();
        end

        // Extremes: largest node count, block and share, the top base, bad settings.
        configure(phm_pkg::POL_PRIME_BLK, 7'd64, phm_pkg::BP_MAX, phm_pkg::NSB_MAX,
                  48'hFFFF_FFFF_FFFF);
        send_address(48'hFFFF_FFFF_FFFF);
        send_address(48'hFFFF_FFFF_FFFE);
        drain();
        configure(3'd7, 7'd1, 17'd1, 33'd1, 48'd0);
        send_address(48'h0);
        drain();
        configure(phm_pkg::POL_CYCLIC, 7'd0, 17'd1, phm_pkg::NSB_MAX, 48'd0);
        send_address(48'h1000);
        drain();
        configure(phm_pkg::POL_CYCLIC, 7'd127, 17'h1FFFF, 33'h1_FFFF_FFFF, 48'd0);
        send_address(48'h1000);
        drain();
        configure(phm_pkg::POL_BINDALL, 7'd1, 17'd0, 33'd0, 48'd0);
        send_address(48'h1000);
        drain();

        // Random phases; one with no idling and one with a long receiver hold-off.
        for (int ph = 0; ph < 26; ph++) begin
            quiet = (ph == 7);
            if (ph == 12)
                hold_request = 600;
            random_phase(40);
        end
        quiet = 0;
        drain();

        $display("Sent %0d addresses through %0d register writes across all seven policies.",
                 items_sent, cfg_count);
        $display("Checked %0d results, %0d of them range errors.", result_count, error_count);
        if (fail_count == 0 && open_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
